[design/psa_pkg.sv]
`timescale 1ns / 1ps
package psa_pkg;
   localparam int TableEntriesDefault = 32;
   localparam int SlotsDefault = 16;

   typedef enum logic [2:0] {
      OP_FIT = 3'd0, OP_BUMP = 3'd1, OP_REL = 3'd2, OP_RELALL = 3'd3,
      OP_RESERVE = 3'd4, OP_CLEAR = 3'd5, OP_QUERY = 3'd6, OP_NONE = 3'd7
   } op_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_DUP = 3'd2;
   localparam logic [2:0] ST_NOSPACE = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_BUMPOVF = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] resource_id;
      logic [1:0]  bank_select;
      logic [4:0]  palette_count;
      logic [15:0] reserve_mask;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] base_main;
      logic [3:0] base_sub;
      logic       found;
   } rsp_type;

   // owner entry: valid, base sub, base main, count, banks, id
   typedef struct packed {
      logic        valid;
      logic [3:0]  bsub;
      logic [3:0]  bmain;
      logic [4:0]  count;
      logic [1:0]  banks;
      logic [15:0] id;
   } entry_type;

   function automatic logic [15:0] run_mask(input logic [3:0] base, input logic [4:0] count);
      logic [15:0] m;
      if (count >= 5'd16) m = 16'hffff;
      else m = 16'((17'd1 << count) - 17'd1);
      return m << base;
   endfunction
endpackage

[design/psa_if.sv]
`timescale 1ns / 1ps
interface psa_req_if;
   import psa_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface psa_rsp_if;
   import psa_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

[design/palette_slot_allocator.sv]
`timescale 1ns / 1ps
// flow: every request scans the owner table; first-fit then probes the slot bases
// (one slot base per cycle over 17 bases), and release all then sweeps the table,
// reading, latching and releasing each entry in turn
// requests: one at a time, the next one accepted in the cycle after the response is taken;
// the owner table memory port sets the scan length
// reset: after reset a clearing pass writes every table entry free,
// no request is taken during it; bitmaps and bump pointers reset to zero
module palette_slot_allocator #(
   parameter int TABLE_ENTRIES = psa_pkg::TableEntriesDefault
) (
   input logic clock,
   input logic reset,
   psa_req_if.sink   req,
   psa_rsp_if.source rsp
);
   import psa_pkg::*;
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);
   localparam logic [5:0] SLOT_LIM = 6'(SlotsDefault);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN, S_SCANW, S_FIT, S_DO, S_SWEEP, S_SWEEPW, S_REL, S_OUT
   } state_type;

   state_type state_ff;
   req_type   r_ff;
   logic [CW-1:0] idx_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   entry_type     wr_data, rd_e;
   logic [31:0]   rd_raw;
   logic [15:0] occ_m_ff, occ_s_ff;
   logic [4:0]  bump_m_ff, bump_s_ff;
   logic        hit_ff, free_ok_ff;
   logic [AW-1:0] hit_idx_ff, free_idx_ff, last_idx_ff;
   logic [4:0]  s_ff;
   logic        fm_ok_ff, fs_ok_ff;
   logic [3:0]  fm_ff, fs_ff;
   entry_type   hit_e_ff;
   rsp_type     out_ff;
   logic        out_v_ff;

   psa_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );
   assign rd_e = entry_type'(rd_raw);

   assign req.ready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.payload = out_ff;

   logic sel_m, sel_s;
   assign sel_m = r_ff.bank_select[0];
   assign sel_s = r_ff.bank_select[1];

   // bump checks and first-fit probe
   logic ovf;
   assign ovf = (sel_m && (6'(bump_m_ff) >= SLOT_LIM ||
                           6'(bump_m_ff) + 6'(r_ff.palette_count) > SLOT_LIM))
             || (sel_s && (6'(bump_s_ff) >= SLOT_LIM ||
                           6'(bump_s_ff) + 6'(r_ff.palette_count) > SLOT_LIM));
   logic [15:0] probe;
   logic        fit_in;
   assign probe  = run_mask(s_ff[3:0], r_ff.palette_count);
   assign fit_in = 6'(s_ff) + 6'(r_ff.palette_count) <= SLOT_LIM;

   // response for the request being completed
   rsp_type do_rsp;
   always_comb begin
      do_rsp = '{status: ST_OK, base_main: 4'd0, base_sub: 4'd0, found: hit_ff};
      case (r_ff.operation)
         OP_FIT, OP_BUMP: begin
            if (!free_ok_ff) do_rsp.status = ST_FULL;
            else if (hit_ff) do_rsp.status = ST_DUP;
            else if (r_ff.operation == OP_FIT) begin
               if ((sel_m && !fm_ok_ff) || (sel_s && !fs_ok_ff))
                  do_rsp.status = ST_NOSPACE;
               else begin
                  do_rsp.base_main = sel_m ? fm_ff : 4'd0;
                  do_rsp.base_sub = sel_s ? fs_ff : 4'd0;
                  do_rsp.found = 1'b1;
               end
            end else if (ovf) do_rsp.status = ST_BUMPOVF;
            else begin
               do_rsp.base_main = sel_m ? bump_m_ff[3:0] : 4'd0;
               do_rsp.base_sub = sel_s ? bump_s_ff[3:0] : 4'd0;
               do_rsp.found = 1'b1;
            end
         end
         OP_REL: begin
            do_rsp.found = 1'b0;
            if (!hit_ff) do_rsp.status = ST_NOTFOUND;
         end
         default: ;
      endcase
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = '0;
      rd_addr = idx_ff[AW-1:0];
      if (state_ff == S_INIT) wr_en = 1'b1;
      if (state_ff == S_SWEEPW && rd_e.valid) begin
         wr_en = 1'b1;
         wr_addr = last_idx_ff;
      end
      if (state_ff == S_DO) begin
         if ((r_ff.operation == OP_FIT || r_ff.operation == OP_BUMP) && free_ok_ff && !hit_ff) begin
            wr_addr = free_idx_ff;
            wr_data.valid = 1'b1;
            wr_data.id = r_ff.resource_id;
            wr_data.banks = r_ff.bank_select;
            wr_data.count = r_ff.palette_count;
            if (r_ff.operation == OP_FIT) begin
               wr_data.bmain = sel_m ? fm_ff : 4'd0;
               wr_data.bsub  = sel_s ? fs_ff : 4'd0;
               wr_en = (!sel_m || fm_ok_ff) && (!sel_s || fs_ok_ff);
            end else begin
               wr_data.bmain = sel_m ? bump_m_ff[3:0] : 4'd0;
               wr_data.bsub  = sel_s ? bump_s_ff[3:0] : 4'd0;
               wr_en = !ovf;
            end
         end else if (r_ff.operation == OP_REL && hit_ff) begin
            wr_en = 1'b1;
            wr_addr = hit_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff <= '0;
         occ_m_ff <= '0;
         occ_s_ff <= '0;
         bump_m_ff <= '0;
         bump_s_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         case (state_ff)
            S_INIT: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST) state_ff <= S_IDLE;
            end
            S_IDLE: if (req.valid && !out_v_ff) begin
               r_ff <= req.payload;
               idx_ff <= '0;
               hit_ff <= 1'b0;
               free_ok_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            // issue reads, examine the registered read data in the next cycle
            S_SCAN: begin
               last_idx_ff <= idx_ff[AW-1:0];
               idx_ff <= idx_ff + 1'b1;
               state_ff <= S_SCANW;
            end
            S_SCANW: begin
               if (rd_e.valid && rd_e.id == r_ff.resource_id && !hit_ff) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= last_idx_ff;
                  hit_e_ff <= rd_e;
               end
               if (!rd_e.valid && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  free_idx_ff <= last_idx_ff;
               end
               if (last_idx_ff == LAST[AW-1:0]) begin
                  s_ff <= '0;
                  fm_ok_ff <= 1'b0;
                  fs_ok_ff <= 1'b0;
                  fm_ff <= '0;
                  fs_ff <= '0;
                  if (r_ff.operation == OP_FIT) state_ff <= S_FIT;
                  else if (r_ff.operation == OP_RELALL) begin
                     idx_ff <= '0;
                     state_ff <= S_SWEEP;
                  end else state_ff <= S_DO;
               end else begin
                  last_idx_ff <= idx_ff[AW-1:0];
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FIT: begin
               if (fit_in) begin
                  if (!fm_ok_ff && ((occ_m_ff & probe) == 16'd0 || r_ff.palette_count == 5'd0)) begin
                     fm_ok_ff <= 1'b1;
                     fm_ff <= s_ff[3:0];
                  end
                  if (!fs_ok_ff && ((occ_s_ff & probe) == 16'd0 || r_ff.palette_count == 5'd0)) begin
                     fs_ok_ff <= 1'b1;
                     fs_ff <= s_ff[3:0];
                  end
               end
               s_ff <= s_ff + 1'b1;
               if (s_ff == 5'd16) state_ff <= S_DO;
            end
            S_SWEEP: begin
               last_idx_ff <= idx_ff[AW-1:0];
               idx_ff <= idx_ff + 1'b1;
               state_ff <= S_SWEEPW;
            end
            S_SWEEPW: begin
               hit_e_ff <= rd_e;
               state_ff <= S_REL;
            end
            S_REL: begin
               if (hit_e_ff.valid) begin
                  if (hit_e_ff.banks[0])
                     occ_m_ff <= occ_m_ff & ~run_mask(hit_e_ff.bmain, hit_e_ff.count);
                  if (hit_e_ff.banks[1])
                     occ_s_ff <= occ_s_ff & ~run_mask(hit_e_ff.bsub, hit_e_ff.count);
               end
               if (last_idx_ff == LAST[AW-1:0]) begin
                  hit_ff <= 1'b0;
                  out_ff <= '{status: ST_OK, base_main: 4'd0, base_sub: 4'd0, found: 1'b0};
                  state_ff <= S_OUT;
               end else state_ff <= S_SWEEP;
            end
            S_DO: begin
               out_ff <= do_rsp;
               case (r_ff.operation)
                  OP_FIT, OP_BUMP: if (do_rsp.status == ST_OK) begin
                     if (sel_m)
                        occ_m_ff <= occ_m_ff | run_mask(do_rsp.base_main, r_ff.palette_count);
                     if (sel_s)
                        occ_s_ff <= occ_s_ff | run_mask(do_rsp.base_sub, r_ff.palette_count);
                     if (r_ff.operation == OP_BUMP) begin
                        if (sel_m) bump_m_ff <= bump_m_ff + r_ff.palette_count;
                        if (sel_s) bump_s_ff <= bump_s_ff + r_ff.palette_count;
                     end
                  end
                  OP_REL: if (hit_ff) begin
                     if (hit_e_ff.banks[0])
                        occ_m_ff <= occ_m_ff & ~run_mask(hit_e_ff.bmain, hit_e_ff.count);
                     if (hit_e_ff.banks[1])
                        occ_s_ff <= occ_s_ff & ~run_mask(hit_e_ff.bsub, hit_e_ff.count);
                  end
                  OP_RESERVE: begin
                     if (sel_m) occ_m_ff <= occ_m_ff | r_ff.reserve_mask;
                     if (sel_s) occ_s_ff <= occ_s_ff | r_ff.reserve_mask;
                  end
                  OP_CLEAR: begin
                     occ_m_ff <= '0;
                     occ_s_ff <= '0;
                     bump_m_ff <= '0;
                     bump_s_ff <= '0;
                  end
                  default: ;
               endcase
               state_ff <= S_OUT;
            end
            S_OUT: begin
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> out_v_ff) else $error("response not raised");
   a_bump_range: assert property (@(posedge clock) disable iff (reset)
      bump_m_ff <= 5'd16 && bump_s_ff <= 5'd16) else $error("bump pointer out of range");
endmodule

[design/psa_ram.sv]
`timescale 1ns / 1ps
module psa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule
